FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OFT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication a fixed number of cycles later.
`define OFT_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("delayed check failed");

`endif

FILE: rtl/ofreq_pkg.sv
// ----------------------------------------------------------------------------
// ofreq_pkg
// Types and constants of the on-demand frequency target block.
// ----------------------------------------------------------------------------
package ofreq_pkg;

   localparam int unsigned FREQ_W   = 32;
   localparam int unsigned CFG_W    = 7;
   localparam int unsigned COUNT_W  = 25;   // counts after the large-count shift
   localparam int unsigned DIV_BITS = 32;   // quotient bits of each divider

   localparam logic [CFG_W-1:0]  UP_DEFAULT   = 7'd90;
   localparam logic [CFG_W-1:0]  DOWN_DEFAULT = 7'd5;
   localparam logic [CFG_W-1:0]  PERCENT      = 7'd100;
   localparam int unsigned       COUNT_SHIFT  = 7;
   localparam logic [FREQ_W-1:0] MAX_FREQ     = 32'hFFFF_FFFF;

   localparam logic [2:0] DEC_SCALED  = 3'd0;
   localparam logic [2:0] DEC_KEPT    = 3'd1;
   localparam logic [2:0] DEC_NO_TIME = 3'd2;
   localparam logic [2:0] DEC_BUSY    = 3'd3;
   localparam logic [2:0] DEC_UNKNOWN = 3'd4;
   localparam logic [2:0] DEC_CFG_ERR = 3'd5;

   localparam logic CSR_UP   = 1'b0;
   localparam logic CSR_DOWN = 1'b1;

   typedef struct packed {
      logic [FREQ_W-1:0] busy_cnt;
      logic [FREQ_W-1:0] total_cnt;
      logic [FREQ_W-1:0] cur_freq;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0] target_frequency;
      logic [2:0]        decision;
   } rsp_type;

endpackage

FILE: rtl/ondemand_frequency_target.sv
// ----------------------------------------------------------------------------
// ondemand_frequency_target
// A request passes through the registers stage 1, stage 2, divider A, middle,
// divider B and the output register before rsp_valid rises with its result.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth comes from two restoring dividers of 32 stages, one bit each.
// Reset (synchronous) clears all stage valid bits and loads thresholds 90/5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ondemand_frequency_target (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ofreq_pkg::req_type         req_data,
   output logic                       rsp_valid,
   output ofreq_pkg::rsp_type         rsp_data,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [ofreq_pkg::CFG_W-1:0] csr_data
);

   localparam int unsigned LATENCY = 2 * ofreq_pkg::DIV_BITS + 4;

   // first stage: effective config and shifted counts
   typedef struct packed {
      logic                              valid;
      logic                              cfg_err;
      logic                              no_time;
      logic [ofreq_pkg::COUNT_W-1:0]     busy_c;
      logic [ofreq_pkg::COUNT_W-1:0]     total_c;
      logic [ofreq_pkg::FREQ_W-1:0]      freq;
      logic [ofreq_pkg::CFG_W-1:0]       up;
      logic [ofreq_pkg::CFG_W-1:0]       down;
   } s1_type;

   // shared shape of every divider stage; the second divider uses the low
   // bits of rem and divisor only
   typedef struct packed {
      logic                              valid;
      logic [2:0]                        decision;
      logic [ofreq_pkg::FREQ_W-1:0]      target;
      logic                              sat;
      logic [ofreq_pkg::CFG_W-1:0]       div2;
      logic [ofreq_pkg::COUNT_W-1:0]     divisor;
      logic [ofreq_pkg::COUNT_W-1:0]     rem;
      logic [ofreq_pkg::DIV_BITS-1:0]    work;   // dividend bits out, quotient in
   } stage_type;

   // one restoring step: one quotient bit
   function automatic stage_type div_step(input stage_type s);
      stage_type                     r;
      logic [ofreq_pkg::COUNT_W:0]   trial;
      logic                          qbit;
      r     = s;
      trial = {s.rem, s.work[ofreq_pkg::DIV_BITS-1]};
      qbit  = (trial >= {1'b0, s.divisor});
      if (qbit) begin
         trial = trial - {1'b0, s.divisor};
      end
      r.rem  = trial[ofreq_pkg::COUNT_W-1:0];
      r.work = {s.work[ofreq_pkg::DIV_BITS-2:0], qbit};
      return r;
   endfunction

   logic [ofreq_pkg::CFG_W-1:0] up_ff, up_in;
   logic [ofreq_pkg::CFG_W-1:0] down_ff, down_in;

   s1_type    s1_ff, s1_in;
   stage_type s2_ff, s2_in;
   stage_type a_ff [ofreq_pkg::DIV_BITS];
   stage_type a_in [ofreq_pkg::DIV_BITS];
   stage_type mid_ff, mid_in;
   stage_type b_ff [ofreq_pkg::DIV_BITS];
   stage_type b_in [ofreq_pkg::DIV_BITS];
   logic                   rsp_valid_ff, rsp_valid_in;
   ofreq_pkg::rsp_type     rsp_ff, rsp_in;

   logic req_fire;

   // never stalls
   assign busy     = 1'b0;
   assign req_fire = start & ~busy;

   // ---------------------------------------------------------------- config
   always_comb begin
      up_in   = up_ff;
      down_in = down_ff;
      if (csr_write) begin
         case (csr_index)
            ofreq_pkg::CSR_UP: begin
               up_in = csr_data;
            end
            ofreq_pkg::CSR_DOWN: begin
               down_in = csr_data;
            end
            default: begin
               up_in = up_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   // zero register value means default; large counts are scaled down by 2^7
   always_comb begin
      logic [ofreq_pkg::CFG_W-1:0]  up_e;
      logic [ofreq_pkg::CFG_W-1:0]  down_e;
      logic                         big;
      logic [ofreq_pkg::FREQ_W-1:0] bsh;
      logic [ofreq_pkg::FREQ_W-1:0] tsh;
      up_e   = (up_ff   != '0) ? up_ff   : ofreq_pkg::UP_DEFAULT;
      down_e = (down_ff != '0) ? down_ff : ofreq_pkg::DOWN_DEFAULT;
      big    = (req_data.busy_cnt[31:24] != '0) || (req_data.total_cnt[31:24] != '0);
      bsh    = big ? (req_data.busy_cnt  >> ofreq_pkg::COUNT_SHIFT) : req_data.busy_cnt;
      tsh    = big ? (req_data.total_cnt >> ofreq_pkg::COUNT_SHIFT) : req_data.total_cnt;
      s1_in.valid   = req_fire;
      s1_in.cfg_err = (up_e > ofreq_pkg::PERCENT) || (up_e < down_e);
      s1_in.no_time = (req_data.total_cnt == '0);
      s1_in.busy_c  = bsh[ofreq_pkg::COUNT_W-1:0];
      s1_in.total_c = tsh[ofreq_pkg::COUNT_W-1:0];
      s1_in.freq    = req_data.cur_freq;
      s1_in.up      = up_e;
      s1_in.down    = down_e;
   end

   // ---------------------------------------------------------------- stage 2
   // load compares, decision, and the busy*freq product for divider A.
   // On the scaled path busy <= total, so the first quotient fits 32 bits.
   always_comb begin
      logic [31:0]                  b100;
      logic [31:0]                  tup;
      logic [31:0]                  tkeep;
      logic [ofreq_pkg::CFG_W-1:0]  band;
      logic [56:0]                  prod;
      band  = s1_ff.up - s1_ff.down;
      b100  = 32'(s1_ff.busy_c)  * 32'(ofreq_pkg::PERCENT);
      tup   = 32'(s1_ff.total_c) * 32'(s1_ff.up);
      tkeep = 32'(s1_ff.total_c) * 32'(band);
      prod  = 57'(s1_ff.busy_c)  * 57'(s1_ff.freq);

      s2_in.valid   = s1_ff.valid;
      s2_in.sat     = 1'b0;
      s2_in.div2    = s1_ff.up - (s1_ff.down >> 1);
      s2_in.divisor = s1_ff.total_c;
      s2_in.rem     = prod[56:32];
      s2_in.work    = prod[31:0];
      if (s1_ff.cfg_err) begin
         s2_in.decision = ofreq_pkg::DEC_CFG_ERR;
         s2_in.target   = '0;
      end else if (s1_ff.no_time) begin
         s2_in.decision = ofreq_pkg::DEC_NO_TIME;
         s2_in.target   = ofreq_pkg::MAX_FREQ;
      end else if (b100 > tup) begin
         s2_in.decision = ofreq_pkg::DEC_BUSY;
         s2_in.target   = ofreq_pkg::MAX_FREQ;
      end else if (s1_ff.freq == '0) begin
         s2_in.decision = ofreq_pkg::DEC_UNKNOWN;
         s2_in.target   = ofreq_pkg::MAX_FREQ;
      end else if (b100 > tkeep) begin
         s2_in.decision = ofreq_pkg::DEC_KEPT;
         s2_in.target   = s1_ff.freq;
      end else begin
         s2_in.decision = ofreq_pkg::DEC_SCALED;
         s2_in.target   = '0;
      end
   end

   // ---------------------------------------------------------------- divider A
   // busy*freq / total, one bit a stage
   always_comb begin
      a_in[0] = div_step(s2_ff);
      for (int i = 1; i < ofreq_pkg::DIV_BITS; i++) begin
         a_in[i] = div_step(a_ff[i-1]);
      end
   end

   // ---------------------------------------------------------------- middle
   // q*100; quotient by div2 overflows 32 bits when the top bits reach div2
   always_comb begin
      logic [38:0] m;
      m = 39'(a_ff[ofreq_pkg::DIV_BITS-1].work) * 39'(ofreq_pkg::PERCENT);
      mid_in         = a_ff[ofreq_pkg::DIV_BITS-1];
      mid_in.sat     = (m[38:32] >= a_ff[ofreq_pkg::DIV_BITS-1].div2);
      mid_in.divisor = ofreq_pkg::COUNT_W'(a_ff[ofreq_pkg::DIV_BITS-1].div2);
      mid_in.rem     = ofreq_pkg::COUNT_W'(m[38:32]);
      mid_in.work    = m[31:0];
   end

   // ---------------------------------------------------------------- divider B
   always_comb begin
      b_in[0] = div_step(mid_ff);
      for (int i = 1; i < ofreq_pkg::DIV_BITS; i++) begin
         b_in[i] = div_step(b_ff[i-1]);
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      stage_type last;
      last                    = b_ff[ofreq_pkg::DIV_BITS-1];
      rsp_valid_in            = last.valid;
      rsp_in.decision         = last.decision;
      if (last.decision == ofreq_pkg::DEC_SCALED) begin
         rsp_in.target_frequency = last.sat ? ofreq_pkg::MAX_FREQ : last.work;
      end else begin
         rsp_in.target_frequency = last.target;
      end
   end

   // ---------------------------------------------------------------- registers
   // only valid bits and thresholds are reset; stage data holds, rsp data keeps loading
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         mid_ff.valid <= 1'b0;
         for (int i = 0; i < ofreq_pkg::DIV_BITS; i++) begin
            a_ff[i].valid <= 1'b0;
            b_ff[i].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
         up_ff        <= ofreq_pkg::UP_DEFAULT;
         down_ff      <= ofreq_pkg::DOWN_DEFAULT;
      end else begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         mid_ff <= mid_in;
         for (int i = 0; i < ofreq_pkg::DIV_BITS; i++) begin
            a_ff[i] <= a_in[i];
            b_ff[i] <= b_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   `OFT_ASSERT_DELAY(a_latency, clock, reset, req_fire, LATENCY, rsp_valid)
   `OFT_ASSERT_IMPL(a_cfg_zero, clock, reset,
      rsp_valid && (rsp_data.decision == ofreq_pkg::DEC_CFG_ERR),
      rsp_data.target_frequency == '0)
   `OFT_ASSERT_IMPL(a_kept_known, clock, reset,
      rsp_valid && (rsp_data.decision == ofreq_pkg::DEC_KEPT),
      rsp_data.target_frequency != '0)
   `OFT_ASSERT_IMPL(a_code_range, clock, reset, rsp_valid,
      rsp_data.decision <= ofreq_pkg::DEC_CFG_ERR)

endmodule
